/* src/pfx_pkg.sv */
// Package for the postfix expression evaluator.
// Holds the symbol and status codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package pfx_pkg;

    // Operator characters and the digit zero.
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_ZERO = 8'h30;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input channel ready
        logic push;        // push the latched operand
        logic rd_lhs;      // read the left operand from the stack memory
        logic note_under;  // record an underflow
        logic wr_alu;      // replace both operands by the ALU result
        logic wr_zero;     // replace both operands by zero, record divide by zero
        logic div_start;   // start the serial divider
        logic wr_div;      // replace both operands by the quotient
        logic emit;        // load the result register and clear the stack
    } pfx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_fire;
        logic is_op;
        logic is_div;
        logic last;
        logic sp_lt2;
        logic rhs_zero;
        logic div_done;
        logic out_free;
    } pfx_sts_t;

    // Keeps only the first error of an expression.
    function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
        note_err = (cur == ST_OK) ? code : cur;
    endfunction

endpackage

`default_nettype wire

/* src/pfx_sym_if.sv */
// Input channel interface: one expression character per transfer.
// Depends on nothing.
`default_nettype none

interface pfx_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

/* src/pfx_res_if.sv */
// Result channel interface: value and status of one expression per transfer.
// Depends on nothing.
`default_nettype none

interface pfx_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

/* src/pfx_div.sv */
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
`default_nettype none

module pfx_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] mb_reg, mb_next;
    logic        neg_reg, neg_next;
    logic [33:0] diff;

    always_comb
    begin
        diff      = {1'b0, rem_reg, q_reg[31]} - {2'b00, mb_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend[31] ? (32'd0 - dividend) : dividend;
            mb_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            rem_next  = '0;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            // Restoring step: keep the trial remainder when it does not go negative.
            if (!diff[33])
            begin
                rem_next = diff[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], q_reg[31]};
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - q_reg) : q_reg;

endmodule

`default_nettype wire

/* src/pfx_ctrl.sv */
// Controller state machine of the postfix evaluator.
// Depends on pfx_pkg for the command and status structs.
`default_nettype none

module pfx_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pfx_pkg::pfx_sts_t sts,
    output pfx_pkg::pfx_cmd_t     cmd
);

    import pfx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_OPRD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    state_t after_item;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        after_item = sts.last ? S_DONE : S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = 1'b1;
                if (sts.in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!sts.is_op)
                begin
                    cmd.push   = 1'b1;
                    state_next = after_item;
                end
                else if (sts.sp_lt2)
                begin
                    cmd.note_under = 1'b1;
                    state_next     = after_item;
                end
                else
                begin
                    cmd.rd_lhs = 1'b1;
                    state_next = S_OPRD;
                end
            end
            S_OPRD:
            begin
                if (!sts.is_div)
                begin
                    cmd.wr_alu = 1'b1;
                    state_next = after_item;
                end
                else if (sts.rhs_zero)
                begin
                    cmd.wr_zero = 1'b1;
                    state_next  = after_item;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.wr_div = 1'b1;
                    state_next = after_item;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* src/pfx_dp.sv */
// Datapath of the postfix evaluator: stack memory, top-of-stack register, ALU,
// serial divider, status and result register. Depends on pfx_pkg, the channel
// interfaces and pfx_div.
`default_nettype none

module pfx_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    pfx_sym_if.sink                symbols,
    pfx_res_if.source              results,
    input  wire pfx_pkg::pfx_cmd_t cmd,
    output pfx_pkg::pfx_sts_t      sts
);

    import pfx_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Entries below the top live in memory; the top entry is held in tos_reg.
    logic [31:0] stack_mem [STACK_DEPTH];

    logic [SP_W-1:0] sp_reg, sp_next;
    logic [1:0]      err_reg, err_next;
    logic [31:0]     tos_reg, tos_next;
    logic [31:0]     lhs_reg;
    logic [7:0]      sym_reg;
    logic            last_reg;
    logic            res_valid_reg, res_valid_next;
    logic [31:0]     value_reg;
    logic [1:0]      status_reg;

    logic [SP_W-1:0]  sp_m1, sp_m2;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic             mem_we;
    logic             full;
    logic             in_fire;
    logic             out_free;
    logic [31:0]      push_val;
    logic [31:0]      alu_res;
    logic             div_done;
    logic [31:0]      div_q;

    assign in_fire  = symbols.valid && cmd.accept;
    assign out_free = !res_valid_reg || results.ready;
    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign wr_idx   = sp_m1[IDX_W-1:0];
    assign rd_idx   = sp_m2[IDX_W-1:0];
    assign full     = (sp_reg == SP_W'(STACK_DEPTH));
    assign push_val = {24'd0, sym_reg} - {24'd0, SYM_ZERO};

    always_comb
    begin
        unique case (sym_reg)
            SYM_ADD: alu_res = lhs_reg + tos_reg;
            SYM_MUL: alu_res = lhs_reg * tos_reg;
            default: alu_res = lhs_reg - tos_reg;
        endcase
    end

    pfx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (lhs_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        sp_next        = sp_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        mem_we         = 1'b0;
        res_valid_next = res_valid_reg;
        if (results.ready)
            res_valid_next = 1'b0;
        if (cmd.push)
        begin
            if (full)
                err_next = note_err(err_reg, ST_OVER);
            else
            begin
                mem_we   = (sp_reg != '0);
                tos_next = push_val;
                sp_next  = sp_reg + SP_W'(1);
            end
        end
        if (cmd.note_under)
            err_next = note_err(err_reg, ST_UNDER);
        if (cmd.wr_alu)
        begin
            tos_next = alu_res;
            sp_next  = sp_m1;
        end
        if (cmd.wr_zero)
        begin
            tos_next = '0;
            sp_next  = sp_m1;
            err_next = note_err(err_reg, ST_DIV0);
        end
        if (cmd.wr_div)
        begin
            tos_next = div_q;
            sp_next  = sp_m1;
        end
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
            sp_next        = '0;
            err_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (in_fire)
        begin
            sym_reg  <= symbols.symbol;
            last_reg <= symbols.last;
        end
        if (cmd.emit)
        begin
            // An empty stack gives zero and, unless an error came first, underflow.
            value_reg  <= (sp_reg != '0) ? tos_reg : 32'd0;
            status_reg <= (sp_reg != '0) ? err_reg : note_err(err_reg, ST_UNDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[wr_idx] <= tos_reg;
        if (cmd.rd_lhs)
            lhs_reg <= stack_mem[rd_idx];
    end

    assign symbols.ready  = cmd.accept;
    assign results.valid  = res_valid_reg;
    assign results.value  = value_reg;
    assign results.status = status_reg;

    assign sts.in_fire  = in_fire;
    assign sts.is_op    = (sym_reg == SYM_ADD) || (sym_reg == SYM_SUB) ||
                          (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV);
    assign sts.is_div   = (sym_reg == SYM_DIV);
    assign sts.last     = last_reg;
    assign sts.sp_lt2   = (sp_reg < SP_W'(2));
    assign sts.rhs_zero = (tos_reg == 32'd0);
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

endmodule

`default_nettype wire

/* src/postfix_expression_evaluator_top.sv */
// Top level of the postfix (RPN) expression evaluator.
// Depends on pfx_pkg, pfx_sym_if, pfx_res_if, pfx_ctrl and pfx_dp (which holds pfx_div).
//
//   Channel   Direction  Payload                     One transfer is
//   symbols   in         symbol[7:0], last           one expression character
//   results   out        value[31:0] signed, status  the outcome of one expression
//
// An operand is accepted in the idle state and pushed in the execute state. An operator
// with two operands on the stack also reads its left operand from the stack memory
// through a registered read port. A divide by a nonzero divisor then waits for the
// one-bit-per-cycle serial divider and its 32 quotient steps. The character flagged
// last leads to a done state that loads the result register once the result channel
// is free. Reset clears the stack pointer, the status and the result valid; the stack
// memory is not cleared, as only entries below the stack pointer are ever read. While
// a result waits to be taken, the block keeps accepting characters; it stalls only
// when a second expression ends before the first result has been transferred.
`default_nettype none

module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pfx_sym_if.sink   symbols,
    pfx_res_if.source results
);

    import pfx_pkg::*;

    // Controller and datapath talk only through these two structs.
    pfx_cmd_t cmd;
    pfx_sts_t sts;

    pfx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pfx_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols),
        .results (results),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire
